// ===== hdl/gdeo_pkg.sv =====
// Shared types and constants for the depth-oriented edge block.
`timescale 1ns / 1ps
`default_nettype none

package gdeo_pkg;

    // Fixed field widths of the stream payloads.
    localparam int CMD_W    = 3;
    localparam int NODE_W   = 10;
    localparam int VID_W    = 32;
    localparam int STATUS_W = 2;
    localparam int REACH_W  = 11;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 80;

    // Command codes carried in the slave tuser.
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LINK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEED   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RUN    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ORIENT = 3'd4;

    // Status codes carried in the master tuser.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SEED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Datapath micro-operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_SWEEP_INIT,
        OP_SWEEP_ALL,
        OP_SWEEP_DEPTH,
        OP_LINK_RD,
        OP_LINK_WR,
        OP_SEED_RD,
        OP_SEED_WR,
        OP_WALK_INIT,
        OP_SEEDL_RD,
        OP_SEEDL_DEP,
        OP_SEEDL_CHK,
        OP_POP,
        OP_NODE_RD,
        OP_NODE_LATCH,
        OP_NB_RD,
        OP_NB_DEP,
        OP_NB_CHK,
        OP_ORIENT_RD,
        OP_RESULT
    } t_op;

    // Status returned from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             sweep_last;
        logic             total_zero;
        logic             seeds_done;
        logic             top_zero;
        logic             nb_done;
        logic             out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hdl/graph_depth_edge_orienter.sv =====
// Top level of the depth-oriented edge block: controller plus datapath.
//
//  Channel  Direction  Payload
//  s        in         tuser: cmd; tdata: first_node, second_node, vertex ids
//  m        out        tuser: status; tdata: start id, end id, swapped, reached
//  cfg      in         cfg_wdata: invert
//
// Clear graph and the depth clear of run use a sweep of one entry a cycle.
// After reset a clearing pass over all node entries runs with s_tready low.
// A result waiting on m_tready does not block the next input transaction.
`timescale 1ns / 1ps
`default_nettype none

module graph_depth_edge_orienter #(
    parameter int NODE_COUNT = 1024,
    parameter int MAX_DEGREE = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [2:0] cmd
    input  wire logic [gdeo_pkg::CMD_W-1:0]      i_s_tuser,
    // [9:0] first_node, [19:10] second_node, [51:20] first_vertex_id,
    // [83:52] second_vertex_id, [87:84] zero
    input  wire logic [gdeo_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [1:0] status
    output logic [gdeo_pkg::STATUS_W-1:0]        o_m_tuser,
    // [31:0] out_start_id, [63:32] out_end_id, [64] swapped,
    // [75:65] reached_count, [79:76] zero
    output logic [gdeo_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_wdata
);

    gdeo_pkg::t_op      op;
    gdeo_pkg::t_dp_stat stat;

    // Sequencer.
    gdeo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_op       (op)
    );

    // Memories, counters and result register.
    gdeo_dp #(
        .NODE_COUNT (NODE_COUNT),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_stat      (stat),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tuser   (o_m_tuser),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/gdeo_ctrl.sv =====
// Controller state machine that sequences the datapath operations.
`timescale 1ns / 1ps
`default_nettype none

module gdeo_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire gdeo_pkg::t_dp_stat i_stat,
    output gdeo_pkg::t_op          o_op
);

    typedef enum logic [17:0] {
        S_RSWP   = 18'b000000000000000001,
        S_IDLE   = 18'b000000000000000010,
        S_DECODE = 18'b000000000000000100,
        S_SWALL  = 18'b000000000000001000,
        S_LINK   = 18'b000000000000010000,
        S_SEED   = 18'b000000000000100000,
        S_SWDEP  = 18'b000000000001000000,
        S_WINIT  = 18'b000000000010000000,
        S_SL_RD  = 18'b000000000100000000,
        S_SL_DEP = 18'b000000001000000000,
        S_SL_CHK = 18'b000000010000000000,
        S_POP    = 18'b000000100000000000,
        S_NODE_RD= 18'b000001000000000000,
        S_NODE   = 18'b000010000000000000,
        S_NB_RD  = 18'b000100000000000000,
        S_NB_DEP = 18'b001000000000000000,
        S_NB_CHK = 18'b010000000000000000,
        S_DONE   = 18'b100000000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    // Next state and operation select.
    always_comb begin
        n_state = r_state;
        o_op    = gdeo_pkg::OP_NONE;
        unique case (r_state)
            S_RSWP: begin
                o_op = gdeo_pkg::OP_SWEEP_ALL;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_op    = gdeo_pkg::OP_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.cmd)
                    gdeo_pkg::CMD_CLEAR: begin
                        o_op    = gdeo_pkg::OP_SWEEP_INIT;
                        n_state = S_SWALL;
                    end
                    gdeo_pkg::CMD_LINK: begin
                        o_op    = gdeo_pkg::OP_LINK_RD;
                        n_state = S_LINK;
                    end
                    gdeo_pkg::CMD_SEED: begin
                        o_op    = gdeo_pkg::OP_SEED_RD;
                        n_state = S_SEED;
                    end
                    gdeo_pkg::CMD_RUN: begin
                        o_op    = gdeo_pkg::OP_SWEEP_INIT;
                        n_state = S_SWDEP;
                    end
                    gdeo_pkg::CMD_ORIENT: begin
                        o_op    = gdeo_pkg::OP_ORIENT_RD;
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SWALL: begin
                o_op = gdeo_pkg::OP_SWEEP_ALL;
                if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_LINK: begin
                o_op    = gdeo_pkg::OP_LINK_WR;
                n_state = S_DONE;
            end
            S_SEED: begin
                o_op    = gdeo_pkg::OP_SEED_WR;
                n_state = S_DONE;
            end
            S_SWDEP: begin
                o_op = gdeo_pkg::OP_SWEEP_DEPTH;
                if (i_stat.sweep_last) begin
                    n_state = i_stat.total_zero ? S_DONE : S_WINIT;
                end
            end
            S_WINIT: begin
                o_op    = gdeo_pkg::OP_WALK_INIT;
                n_state = S_SL_RD;
            end
            S_SL_RD: begin
                if (i_stat.seeds_done) begin
                    n_state = S_POP;
                end else begin
                    o_op    = gdeo_pkg::OP_SEEDL_RD;
                    n_state = S_SL_DEP;
                end
            end
            S_SL_DEP: begin
                o_op    = gdeo_pkg::OP_SEEDL_DEP;
                n_state = S_SL_CHK;
            end
            S_SL_CHK: begin
                o_op    = gdeo_pkg::OP_SEEDL_CHK;
                n_state = S_SL_RD;
            end
            S_POP: begin
                if (i_stat.top_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_op    = gdeo_pkg::OP_POP;
                    n_state = S_NODE_RD;
                end
            end
            S_NODE_RD: begin
                o_op    = gdeo_pkg::OP_NODE_RD;
                n_state = S_NODE;
            end
            S_NODE: begin
                o_op    = gdeo_pkg::OP_NODE_LATCH;
                n_state = S_NB_RD;
            end
            S_NB_RD: begin
                if (i_stat.nb_done) begin
                    n_state = S_POP;
                end else begin
                    o_op    = gdeo_pkg::OP_NB_RD;
                    n_state = S_NB_DEP;
                end
            end
            S_NB_DEP: begin
                o_op    = gdeo_pkg::OP_NB_DEP;
                n_state = S_NB_CHK;
            end
            S_NB_CHK: begin
                o_op    = gdeo_pkg::OP_NB_CHK;
                n_state = S_NB_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_op    = gdeo_pkg::OP_RESULT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_RSWP;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RSWP;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gdeo_dp.sv =====
// Datapath: graph memories, walk counters and the result register.
`timescale 1ns / 1ps
`default_nettype none

module gdeo_dp #(
    parameter int NODE_COUNT = 1024,
    parameter int MAX_DEGREE = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire gdeo_pkg::t_op                   i_op,
    output gdeo_pkg::t_dp_stat                   o_stat,
    input  wire logic [gdeo_pkg::CMD_W-1:0]      i_s_tuser,
    input  wire logic [gdeo_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_wdata,
    input  wire logic                            i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [gdeo_pkg::STATUS_W-1:0]        o_m_tuser,
    output logic [gdeo_pkg::OUT_DATA_W-1:0]      o_m_tdata
);

    localparam int NW     = $clog2(NODE_COUNT);
    localparam int DEW    = NW + 1;
    localparam int KW     = $clog2(MAX_DEGREE + 1);
    localparam int CW     = $clog2(NODE_COUNT + 1);
    localparam int TDEPTH = NODE_COUNT * MAX_DEGREE;
    localparam int TW     = $clog2(TDEPTH);

    // Memories.
    logic [NW-1:0]  r_tbl_mem  [TDEPTH];
    logic [KW-1:0]  r_cnt_mem  [NODE_COUNT];
    logic [DEW-1:0] r_dep_mem  [NODE_COUNT];
    logic           r_mark_mem [NODE_COUNT];
    logic [NW-1:0]  r_seed_mem [NODE_COUNT];
    logic [NW-1:0]  r_stk_mem  [NODE_COUNT];

    // Registered read data.
    logic [NW-1:0]  r_tbl_q;
    logic [KW-1:0]  r_cnt_q;
    logic [DEW-1:0] r_dep_a_q;
    logic [DEW-1:0] r_dep_b_q;
    logic           r_mark_q;
    logic [NW-1:0]  r_seed_q;
    logic [NW-1:0]  r_stk_q;

    // Latched transaction and working registers.
    logic [gdeo_pkg::CMD_W-1:0]  r_cmd;
    logic [gdeo_pkg::NODE_W-1:0] r_a;
    logic [gdeo_pkg::NODE_W-1:0] r_b;
    logic [gdeo_pkg::VID_W-1:0]  r_va;
    logic [gdeo_pkg::VID_W-1:0]  r_vb;
    logic [NW-1:0] r_idx;
    logic [CW-1:0] r_total;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_top;
    logic [CW-1:0] r_reached;
    logic [NW-1:0] r_cur;
    logic [NW-1:0] r_cur_dep;
    logic [NW-1:0] r_nb;
    logic [KW-1:0] r_n;
    logic [KW-1:0] r_k;
    logic          r_full;
    logic          r_invert;
    logic          r_out_valid;
    logic [gdeo_pkg::STATUS_W-1:0] r_out_status;
    logic [gdeo_pkg::VID_W-1:0]    r_out_start;
    logic [gdeo_pkg::VID_W-1:0]    r_out_end;
    logic                          r_out_swap;
    logic [gdeo_pkg::REACH_W-1:0]  r_out_reach;

    logic [NW-1:0] a_idx;
    logic [NW-1:0] b_idx;
    logic          a_ok;
    logic          b_ok;
    logic          total_zero;
    logic          out_free;

    assign a_idx      = NW'(r_a);
    assign b_idx      = NW'(r_b);
    assign a_ok       = (32'(r_a) < NODE_COUNT);
    assign b_ok       = (32'(r_b) < NODE_COUNT);
    assign total_zero = (r_total == '0);
    assign out_free   = !r_out_valid || i_m_tready;

    // Status toward the controller.
    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.sweep_last = (r_idx == NW'(NODE_COUNT - 1));
        o_stat.total_zero = total_zero;
        o_stat.seeds_done = (r_i == r_total);
        o_stat.top_zero   = (r_top == '0);
        o_stat.nb_done    = (r_k == r_n);
        o_stat.out_free   = out_free;
    end

    // Memory port control.
    logic           dep_we;
    logic [NW-1:0]  dep_wa;
    logic [DEW-1:0] dep_wd;
    logic           dep_rea;
    logic [NW-1:0]  dep_ra;
    logic           dep_reb;
    logic           cnt_we;
    logic [NW-1:0]  cnt_wa;
    logic [KW-1:0]  cnt_wd;
    logic           cnt_re;
    logic [NW-1:0]  cnt_ra;
    logic           mark_we;
    logic           mark_wd;
    logic           tbl_we;
    logic [TW-1:0]  tbl_wa;
    logic           seed_we;
    logic           push;
    logic [NW-1:0]  push_d;
    logic           link_go;
    logic           seed_go;

    assign link_go = a_ok && b_ok && !(32'(r_cnt_q) >= MAX_DEGREE);
    assign seed_go = a_ok && !r_mark_q && (32'(r_total) < NODE_COUNT);
    assign tbl_wa  = TW'(a_idx) * TW'(MAX_DEGREE) + TW'(r_cnt_q);

    always_comb begin
        dep_we  = 1'b0;
        dep_wa  = r_nb;
        dep_wd  = '0;
        dep_rea = 1'b0;
        dep_ra  = a_idx;
        dep_reb = 1'b0;
        cnt_we  = 1'b0;
        cnt_wa  = a_idx;
        cnt_wd  = r_cnt_q + KW'(1);
        cnt_re  = 1'b0;
        cnt_ra  = a_idx;
        mark_we = 1'b0;
        mark_wd = 1'b1;
        tbl_we  = 1'b0;
        seed_we = 1'b0;
        push    = 1'b0;
        push_d  = r_nb;
        unique case (i_op)
            gdeo_pkg::OP_SWEEP_ALL: begin
                dep_we  = 1'b1;
                dep_wa  = r_idx;
                cnt_we  = 1'b1;
                cnt_wa  = r_idx;
                cnt_wd  = '0;
                mark_we = 1'b1;
                mark_wd = 1'b0;
            end
            gdeo_pkg::OP_SWEEP_DEPTH: begin
                dep_we = 1'b1;
                dep_wa = r_idx;
            end
            gdeo_pkg::OP_LINK_RD: begin
                cnt_re = 1'b1;
            end
            gdeo_pkg::OP_LINK_WR: begin
                cnt_we = link_go;
                tbl_we = link_go;
            end
            gdeo_pkg::OP_SEED_WR: begin
                mark_we = seed_go;
                seed_we = seed_go;
            end
            gdeo_pkg::OP_SEEDL_DEP: begin
                dep_rea = 1'b1;
                dep_ra  = r_seed_q;
            end
            gdeo_pkg::OP_SEEDL_CHK: begin
                dep_we = !r_dep_a_q[NW];
                dep_wd = {1'b1, {NW{1'b0}}};
                push   = !r_dep_a_q[NW];
            end
            gdeo_pkg::OP_NODE_RD: begin
                dep_rea = 1'b1;
                dep_ra  = r_stk_q;
                cnt_re  = 1'b1;
                cnt_ra  = r_stk_q;
            end
            gdeo_pkg::OP_NB_DEP: begin
                dep_rea = 1'b1;
                dep_ra  = r_tbl_q;
            end
            gdeo_pkg::OP_NB_CHK: begin
                dep_we = !r_dep_a_q[NW];
                dep_wd = {1'b1, r_cur_dep + NW'(1)};
                push   = !r_dep_a_q[NW];
            end
            gdeo_pkg::OP_ORIENT_RD: begin
                dep_rea = 1'b1;
                dep_reb = 1'b1;
            end
            default: begin
                dep_we = 1'b0;
            end
        endcase
    end

    // Depth memory: one write port, two read ports.
    always_ff @(posedge i_clk) begin
        if (dep_we) begin
            r_dep_mem[dep_wa] <= dep_wd;
        end
        if (dep_rea) begin
            r_dep_a_q <= r_dep_mem[dep_ra];
        end
        if (dep_reb) begin
            r_dep_b_q <= r_dep_mem[b_idx];
        end
    end

    // Neighbor count memory.
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cnt_re) begin
            r_cnt_q <= r_cnt_mem[cnt_ra];
        end
    end

    // Seed mark memory.
    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            r_mark_mem[mark_we && i_op == gdeo_pkg::OP_SEED_WR ? a_idx : r_idx] <= mark_wd;
        end
        if (i_op == gdeo_pkg::OP_SEED_RD) begin
            r_mark_q <= r_mark_mem[a_idx];
        end
    end

    // Neighbor table memory.
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[tbl_wa] <= b_idx;
        end
        if (i_op == gdeo_pkg::OP_NB_RD) begin
            r_tbl_q <= r_tbl_mem[TW'(r_cur) * TW'(MAX_DEGREE) + TW'(r_k)];
        end
    end

    // Seed list memory.
    always_ff @(posedge i_clk) begin
        if (seed_we) begin
            r_seed_mem[r_total[NW-1:0]] <= a_idx;
        end
        if (i_op == gdeo_pkg::OP_SEEDL_RD) begin
            r_seed_q <= r_seed_mem[r_i[NW-1:0]];
        end
    end

    // Walk stack memory.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stk_mem[r_top[NW-1:0]] <= push_d;
        end
        if (i_op == gdeo_pkg::OP_POP) begin
            r_stk_q <= r_stk_mem[NW'(r_top - CW'(1))];
        end
    end

    // Orientation of the latched edge.
    logic a_reach;
    logic b_reach;
    logic swap;

    assign a_reach = a_ok && r_dep_a_q[NW];
    assign b_reach = b_ok && r_dep_b_q[NW];
    assign swap    = a_reach && b_reach && (r_dep_a_q != r_dep_b_q)
                     && ((r_dep_a_q[NW-1:0] > r_dep_b_q[NW-1:0]) ^ r_invert);

    // Payload registers of the latched transaction and the walk.
    always_ff @(posedge i_clk) begin
        if (i_op == gdeo_pkg::OP_LATCH) begin
            r_cmd <= i_s_tuser;
            r_a   <= i_s_tdata[9:0];
            r_b   <= i_s_tdata[19:10];
            r_va  <= i_s_tdata[51:20];
            r_vb  <= i_s_tdata[83:52];
        end
        if (i_op == gdeo_pkg::OP_LINK_WR) begin
            r_full <= a_ok && b_ok && (32'(r_cnt_q) >= MAX_DEGREE);
        end
        if (i_op == gdeo_pkg::OP_SEEDL_DEP) begin
            r_nb <= r_seed_q;
        end
        if (i_op == gdeo_pkg::OP_NB_DEP) begin
            r_nb <= r_tbl_q;
        end
        if (i_op == gdeo_pkg::OP_NODE_RD) begin
            r_cur <= r_stk_q;
        end
        if (i_op == gdeo_pkg::OP_NODE_LATCH) begin
            r_cur_dep <= r_dep_a_q[NW-1:0];
            r_n       <= r_cnt_q;
        end
        if (i_op == gdeo_pkg::OP_RESULT) begin
            r_out_status <= gdeo_pkg::ST_OK;
            r_out_start  <= '0;
            r_out_end    <= '0;
            r_out_swap   <= 1'b0;
            r_out_reach  <= '0;
            priority if (r_cmd == gdeo_pkg::CMD_LINK) begin
                r_out_status <= r_full ? gdeo_pkg::ST_FULL : gdeo_pkg::ST_OK;
            end else if (r_cmd == gdeo_pkg::CMD_RUN) begin
                r_out_status <= total_zero ? gdeo_pkg::ST_NO_SEED : gdeo_pkg::ST_OK;
                r_out_reach  <= total_zero ? '0 : gdeo_pkg::REACH_W'(r_reached);
            end else if (r_cmd == gdeo_pkg::CMD_ORIENT) begin
                r_out_start <= swap ? r_vb : r_va;
                r_out_end   <= swap ? r_va : r_vb;
                r_out_swap  <= swap;
            end
        end
    end

    // Counters, configuration and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_total     <= '0;
            r_i         <= '0;
            r_top       <= '0;
            r_reached   <= '0;
            r_k         <= '0;
            r_invert    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_invert <= i_cfg_wdata;
            end
            if (i_op == gdeo_pkg::OP_SWEEP_INIT) begin
                r_idx <= '0;
            end
            if (i_op == gdeo_pkg::OP_SWEEP_ALL || i_op == gdeo_pkg::OP_SWEEP_DEPTH) begin
                r_idx <= r_idx + NW'(1);
            end
            if (i_op == gdeo_pkg::OP_SWEEP_ALL) begin
                r_total <= '0;
            end
            if (seed_we) begin
                r_total <= r_total + CW'(1);
            end
            if (i_op == gdeo_pkg::OP_WALK_INIT) begin
                r_i       <= '0;
                r_top     <= '0;
                r_reached <= '0;
            end
            if (i_op == gdeo_pkg::OP_SEEDL_CHK) begin
                r_i <= r_i + CW'(1);
            end
            if (i_op == gdeo_pkg::OP_POP) begin
                r_top <= r_top - CW'(1);
            end
            if (push) begin
                r_top     <= r_top + CW'(1);
                r_reached <= r_reached + CW'(1);
            end
            if (i_op == gdeo_pkg::OP_NODE_LATCH) begin
                r_k <= '0;
            end
            if (i_op == gdeo_pkg::OP_NB_CHK) begin
                r_k <= r_k + KW'(1);
            end
            if (i_op == gdeo_pkg::OP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {4'd0, r_out_reach, r_out_swap, r_out_end, r_out_start};

endmodule

`default_nettype wire
